>>> design/pirl_pkg.sv
// Package for the positional insert/remove list core.
// Holds the sizes, action and status codes, controller state type and command struct.
// No dependencies.
`timescale 1ns / 1ps

package pirl_pkg;

	// list geometry
	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;
	localparam int COUNT_W   = $clog2(CAPACITY + 1);
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int POS_W     = 5;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;

	// action codes
	localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PREPEND   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_POP_BACK  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT = 3'd5;
	localparam logic [ACT_W-1:0] ACT_READ      = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

	// controller states
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // capture the incoming beat
		logic exec;   // apply the captured item to the list
	} cmd_t;

endpackage

>>> design/pirl_ctrl.sv
// Controller for the positional insert/remove list core.
// Two-state machine that sequences capture and execution; uses pirl_pkg.
`timescale 1ns / 1ps

module pirl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output pirl_pkg::cmd_t cmd
);

	pirl_pkg::state_t state_q;
	pirl_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pirl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pirl_pkg::S_IDLE: begin
				if (start) state_d = pirl_pkg::S_EXEC;
			end
			pirl_pkg::S_EXEC: begin
				state_d = pirl_pkg::S_IDLE;
			end
			default: begin
				state_d = pirl_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			pirl_pkg::S_IDLE: begin
				cmd.load = start;
			end
			pirl_pkg::S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

>>> design/pirl_dp.sv
// Datapath for the positional insert/remove list core.
// Item registers, a row of shifting cells, the entry count and result registers; uses pirl_pkg.
`timescale 1ns / 1ps

module pirl_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pirl_pkg::cmd_t                       cmd,
	input  logic [pirl_pkg::ACT_W-1:0]           action,
	input  logic signed [pirl_pkg::WORD_BITS-1:0] value,
	input  logic [pirl_pkg::POS_W-1:0]           position,
	output logic                                 done,
	output logic signed [pirl_pkg::WORD_BITS-1:0] data,
	output logic [pirl_pkg::COUNT_W-1:0]         count,
	output logic [pirl_pkg::STAT_W-1:0]          status
);

	localparam int CMP_W = (pirl_pkg::POS_W > pirl_pkg::COUNT_W) ?
		pirl_pkg::POS_W : pirl_pkg::COUNT_W;

	// captured item
	logic [pirl_pkg::ACT_W-1:0]     action_q;
	logic [pirl_pkg::WORD_BITS-1:0] value_q;
	logic [pirl_pkg::POS_W-1:0]     position_q;

	// list state
	logic [pirl_pkg::WORD_BITS-1:0] entries_q [pirl_pkg::CAPACITY];
	logic [pirl_pkg::WORD_BITS-1:0] entries_d [pirl_pkg::CAPACITY];
	logic [pirl_pkg::COUNT_W-1:0]   held_q;

	// result registers
	logic                           done_q;
	logic [pirl_pkg::WORD_BITS-1:0] data_q;
	logic [pirl_pkg::COUNT_W-1:0]   count_q;
	logic [pirl_pkg::STAT_W-1:0]    status_q;

	// decode
	logic                           do_ins;
	logic                           do_rem;
	logic                           do_rd;
	logic [pirl_pkg::COUNT_W-1:0]   p;
	logic [pirl_pkg::STAT_W-1:0]    stat_c;
	logic [pirl_pkg::COUNT_W-1:0]   held_d;
	logic [pirl_pkg::WORD_BITS-1:0] rd_word;
	logic                           full;
	logic                           empty;
	logic [CMP_W-1:0]               pos_x;
	logic [CMP_W-1:0]               held_x;

	// capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= action;
			value_q    <= value;
			position_q <= position;
		end
	end

	// classify the action and check bounds
	always_comb begin
		full   = (held_q == pirl_pkg::COUNT_W'(pirl_pkg::CAPACITY));
		empty  = (held_q == '0);
		pos_x  = CMP_W'(position_q);
		held_x = CMP_W'(held_q);
		do_ins = 1'b0;
		do_rem = 1'b0;
		do_rd  = 1'b0;
		p      = '0;
		stat_c = pirl_pkg::STAT_OK;
		case (action_q)
			pirl_pkg::ACT_INSERT: begin
				if (full) stat_c = pirl_pkg::STAT_FULL;
				else if (pos_x > held_x) stat_c = pirl_pkg::STAT_RANGE;
				else begin
					do_ins = 1'b1;
					p      = pirl_pkg::COUNT_W'(position_q);
				end
			end
			pirl_pkg::ACT_APPEND: begin
				if (full) stat_c = pirl_pkg::STAT_FULL;
				else begin
					do_ins = 1'b1;
					p      = held_q;
				end
			end
			pirl_pkg::ACT_PREPEND: begin
				if (full) stat_c = pirl_pkg::STAT_FULL;
				else do_ins = 1'b1;
			end
			pirl_pkg::ACT_REMOVE: begin
				if (empty) stat_c = pirl_pkg::STAT_EMPTY;
				else if (pos_x >= held_x) stat_c = pirl_pkg::STAT_RANGE;
				else begin
					do_rem = 1'b1;
					p      = pirl_pkg::COUNT_W'(position_q);
				end
			end
			pirl_pkg::ACT_POP_BACK: begin
				if (empty) stat_c = pirl_pkg::STAT_EMPTY;
				else begin
					do_rem = 1'b1;
					p      = held_q - pirl_pkg::COUNT_W'(1);
				end
			end
			pirl_pkg::ACT_POP_FRONT: begin
				if (empty) stat_c = pirl_pkg::STAT_EMPTY;
				else do_rem = 1'b1;
			end
			pirl_pkg::ACT_READ: begin
				if (pos_x >= held_x) stat_c = pirl_pkg::STAT_RANGE;
				else begin
					do_rd = 1'b1;
					p     = pirl_pkg::COUNT_W'(position_q);
				end
			end
			default: begin
				stat_c = pirl_pkg::STAT_OK;
			end
		endcase
	end

	// single read port: p is below held whenever the word is used
	assign rd_word = entries_q[p[pirl_pkg::IDX_W-1:0]];

	// new count
	always_comb begin
		held_d = held_q;
		if (do_ins) held_d = held_q + pirl_pkg::COUNT_W'(1);
		else if (do_rem) held_d = held_q - pirl_pkg::COUNT_W'(1);
	end

	// each cell takes its own word, the new value, its lower neighbor's or its upper neighbor's
	always_comb begin
		for (int i = 0; i < pirl_pkg::CAPACITY; i++) begin
			entries_d[i] = entries_q[i];
			if (do_ins) begin
				if (pirl_pkg::COUNT_W'(i) == p) begin
					entries_d[i] = value_q;
				end else if (i > 0 && pirl_pkg::COUNT_W'(i) > p &&
					pirl_pkg::COUNT_W'(i) <= held_q) begin
					entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_rem) begin
				if (i < pirl_pkg::CAPACITY - 1 && pirl_pkg::COUNT_W'(i) >= p &&
					pirl_pkg::COUNT_W'(i + 1) < held_q) begin
					entries_d[i] = entries_q[(i < pirl_pkg::CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	// cell row update
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < pirl_pkg::CAPACITY; i++) begin
				entries_q[i] <= entries_d[i];
			end
		end
	end

	// count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) held_q <= held_d;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			data_q   <= (do_rem || do_rd) ? rd_word : '0;
			count_q  <= held_d;
			status_q <= stat_c;
		end
	end

	assign done   = done_q;
	assign data   = data_q;
	assign count  = count_q;
	assign status = status_q;

endmodule

>>> design/positional_insert_remove_list_core.sv
// Top level of the positional insert/remove list core.
// Joins the controller (pirl_ctrl) and the datapath (pirl_dp); uses pirl_pkg.
`timescale 1ns / 1ps

// Keeps a packed ordered list of up to 16 signed 32-bit words. A beat is taken
// when start is high and busy is low; busy then stays high for one cycle while
// the whole row of cells shifts at once, and the result (data, count, status)
// appears with a one-cycle done strobe on the next cycle, in which a new beat
// may already be taken. An item therefore passes through the capture and then
// the single cell-row update. The receiver cannot stall: results must be taken
// in the cycle done is high. Status 0 ok, 1 full, 2 empty, 3 position out of
// range; failed actions leave the list unchanged.
module positional_insert_remove_list_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [pirl_pkg::ACT_W-1:0]           action,
	input  logic signed [pirl_pkg::WORD_BITS-1:0] value,
	input  logic [pirl_pkg::POS_W-1:0]           position,
	output logic                                 done,
	output logic signed [pirl_pkg::WORD_BITS-1:0] data,
	output logic [pirl_pkg::COUNT_W-1:0]         count,
	output logic [pirl_pkg::STAT_W-1:0]          status
);

	pirl_pkg::cmd_t cmd;

	// sequencing
	pirl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// list storage and result registers
	pirl_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.action   (action),
		.value    (value),
		.position (position),
		.done     (done),
		.data     (data),
		.count    (count),
		.status   (status)
	);

endmodule
